@@ hw/rtl/fva_pkg.sv @@
// Package for the FM voice allocator: event kind codes, action codes and
// the fixed constants of percussion mapping and voice scoring. No dependencies.
package fva_pkg;

    localparam logic [2:0] KIND_NOTE_ON   = 3'd0;
    localparam logic [2:0] KIND_NOTE_OFF  = 3'd1;
    localparam logic [2:0] KIND_PROGRAM   = 3'd2;
    localparam logic [2:0] KIND_ALL_OFF   = 3'd3;
    localparam logic [2:0] KIND_TICK      = 3'd4;

    localparam logic       ACT_KEY_OFF    = 1'b0;
    localparam logic       ACT_KEY_ON     = 1'b1;

    localparam int         CHANNELS       = 16;
    localparam logic [3:0] PERC_CHANNEL   = 4'd9;
    localparam logic [6:0] PERC_LOW       = 7'd35;
    localparam logic [6:0] PERC_HIGH      = 7'd87;
    localparam logic [7:0] PERC_BASE      = 8'd128;

    // scores in units of 0.2 tick
    localparam logic [13:0] FREE_BONUS    = 14'd15000;
    localparam logic [5:0]  PERC_PENALTY  = 6'd45;

    localparam int         NOTE_MAP_DEPTH = 2048;

endpackage

@@ hw/rtl/fm_voice_allocator_unit.sv @@
// FM voice allocator top level: maps MIDI note events onto FM voices.
// Depends on fva_pkg; voice, note-map and active-list memories are inside.
//
// Usage:
//   Input stream s_axis: one event per transfer; tuser carries the kind
//   (note on, note off, program change, all notes off, tick), tdata the
//   channel, note, velocity, program and elapsed ticks.
//   Output stream m_axis: one voice action (key on or key off) per transfer,
//   tlast set on the final action caused by an event.
//   The block works on one event at a time; s_axis_tready is high only when
//   no event is in flight. A note on reads, scores and compares each voice
//   in turn (one voice read, a score add and a compare per voice) and on a
//   steal first releases the winner's note. A note off, and all notes off
//   for each note of the channel, releases a note; the list tail then refills
//   a freed slot that was not the tail. A tick adds the elapsed ticks to each
//   voice's age. Memory reads are registered, with read-modify-write of entries.
//   A finished action sits in the output register; while m_axis stalls the
//   engine holds at the next action and resumes when the transfer completes.
//   After reset a clearing pass zeroes the note map and the voice memory;
//   s_axis_tready stays low until it finishes.
module fm_voice_allocator_unit #(
    parameter int VOICES   = 18,
    parameter int AGE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] channel, [10:4] note, [17:11] velocity, [24:18] program_req,
    // [40:25] elapsed, [47:41] zero
    input  logic [47:0] s_axis_tdata,
    // [2:0] kind
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [4:0] voice, [8:5] out_channel, [15:9] out_note, [23:16] instrument,
    // [30:24] out_velocity, [31] zero
    output logic [31:0] m_axis_tdata,
    // [0] action
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam int VW  = $clog2(VOICES);
    localparam int SW  = $clog2(VOICES + 1);
    localparam int RW  = AGE_BITS + 4;
    localparam int SCW = AGE_BITS + 5;
    localparam int NMW = SW + VW;
    localparam int ALD = fva_pkg::CHANNELS * (2 ** VW);

    typedef struct packed {
        logic                busy;
        logic [7:0]          instr;
        logic [AGE_BITS-1:0] age;
        logic [3:0]          owner;
        logic [SW-1:0]       slot;
    } t_voice;

    // state codes
    localparam logic [4:0] S_CLR = 5'd0,  S_IDLE = 5'd1,  S_LKP = 5'd2,  S_LKD = 5'd3,
                           S_SA  = 5'd4,  S_SB   = 5'd5,  S_SC  = 5'd6,  S_WIN = 5'd7,
                           S_WD  = 5'd8,  S_ON   = 5'd9,  S_R0  = 5'd10, S_R1  = 5'd11,
                           S_R2  = 5'd12, S_R3   = 5'd13, S_R4  = 5'd14, S_R5  = 5'd15,
                           S_R6  = 5'd16, S_R7   = 5'd17, S_R8  = 5'd18, S_R9  = 5'd19,
                           S_R10 = 5'd20, S_R11  = 5'd21, S_RET = 5'd22, S_T0  = 5'd23,
                           S_T1  = 5'd24;
    // where a release returns to
    localparam logic [1:0] RET_DONE = 2'd0, RET_ALL = 2'd1, RET_ON = 2'd2;

    // input fields
    logic [3:0]  in_ch;
    logic [6:0]  in_note, in_vel, in_prog;
    logic [15:0] in_el;
    assign in_ch   = s_axis_tdata[3:0];
    assign in_note = s_axis_tdata[10:4];
    assign in_vel  = s_axis_tdata[17:11];
    assign in_prog = s_axis_tdata[24:18];
    assign in_el   = s_axis_tdata[40:25];

    // memories
    t_voice          vmem [VOICES];
    logic [NMW-1:0]  nmem [fva_pkg::NOTE_MAP_DEPTH];
    logic [6:0]      amem [ALD];
    t_voice          q_v;
    logic [NMW-1:0]  q_n;
    logic [6:0]      q_a;
    logic [VW-1:0]   va, vwa;
    logic [10:0]     na, nwa;
    logic [VW+3:0]   aa, awa;
    logic            vwe, nwe, awe;
    t_voice          vwd;
    logic [NMW-1:0]  nwd;
    logic [6:0]      awd;

    always_ff @(posedge i_clk) begin
        if (vwe) vmem[vwa] <= vwd;
        q_v <= vmem[va];
    end
    always_ff @(posedge i_clk) begin
        if (nwe) nmem[nwa] <= nwd;
        q_n <= nmem[na];
    end
    always_ff @(posedge i_clk) begin
        if (awe) amem[awa] <= awd;
        q_a <= amem[aa];
    end

    // channel registers
    logic [6:0]    r_patch [fva_pkg::CHANNELS];
    logic [SW-1:0] r_count [fva_pkg::CHANNELS];

    // control and working registers
    logic [4:0]           r_state, n_state;
    logic [10:0]          r_clr;
    logic [2:0]           r_kind;
    logic [3:0]           r_ch, r_rch;
    logic [6:0]           r_note, r_vel, r_rnote;
    logic [15:0]          r_el;
    logic [7:0]           r_instr;
    logic [VW-1:0]        r_i, r_best, r_v;
    logic [RW-1:0]        r_raw;
    logic                 r_perc;
    logic [SCW-1:0]       r_bscore;
    logic [SW-1:0]        r_rslot, r_cold;
    logic [1:0]           r_ret;

    // output register
    logic        r_ovld, r_oact, r_olast;
    logic [4:0]  r_ovoice;
    logic [3:0]  r_och;
    logic [6:0]  r_onote, r_ovel;
    logic [7:0]  r_oinstr;

    logic          out_free, in_go;
    logic [3:0]    c_idx;
    logic [SW-1:0] c_cnt;
    logic [13:0]   bonus;
    logic [SCW-1:0] fin;
    logic          is_off, perc_bad;
    logic [AGE_BITS:0] age_sum;

    assign out_free      = !r_ovld || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_go         = s_axis_tvalid && s_axis_tready;
    assign c_idx         = (r_state == S_IDLE) ? in_ch : r_rch;
    assign c_cnt         = r_count[c_idx];

    assign bonus = (q_v.busy ? 14'd0 : fva_pkg::FREE_BONUS) +
                   14'(q_v.instr == r_instr);
    assign fin   = r_perc ? ({r_raw, 1'b0} + SCW'(fva_pkg::PERC_PENALTY))
                          : SCW'(r_raw);
    assign is_off   = (r_kind == fva_pkg::KIND_NOTE_OFF) || (r_vel == 7'd0);
    assign perc_bad = (r_ch == fva_pkg::PERC_CHANNEL) &&
                      ((r_note < fva_pkg::PERC_LOW) || (r_note > fva_pkg::PERC_HIGH));
    assign age_sum  = {1'b0, q_v.age} + (AGE_BITS + 1)'(r_el);

    // memory addressing and writes
    always_comb begin
        va  = r_v;
        na  = {r_rch, r_rnote};
        aa  = {r_rch, VW'(r_rslot - SW'(1))};
        vwe = 1'b0; vwa = r_v; vwd = q_v;
        nwe = 1'b0; nwa = {r_rch, r_rnote}; nwd = q_n;
        awe = 1'b0; awa = {r_rch, VW'(r_rslot - SW'(1))}; awd = q_a;
        case (r_state)
            S_CLR: begin
                nwe = 1'b1; nwa = r_clr; nwd = '0;
                vwe = (r_clr < 11'(VOICES)); vwa = VW'(r_clr); vwd = '0;
            end
            S_LKP, S_LKD: na = {r_ch, r_note};
            S_SA, S_SB, S_T0: va = r_i;
            S_WIN, S_WD: va = r_best;
            S_ON: if (out_free) begin
                vwe = 1'b1; vwa = r_best;
                vwd = '{busy: 1'b1, instr: r_instr, age: '0, owner: r_ch,
                        slot: c_cnt + SW'(1)};
                awe = 1'b1; awa = {r_ch, VW'(c_cnt)}; awd = r_note;
                nwe = 1'b1; nwa = {r_ch, r_note}; nwd = {c_cnt + SW'(1), r_best};
            end
            S_R3: begin
                nwe = 1'b1; nwd = {SW'(0), q_n[VW-1:0]};
            end
            S_R5: if (out_free) begin
                vwe = 1'b1; vwd = q_v; vwd.busy = 1'b0; vwd.age = '0;
            end
            S_R6: aa = {r_rch, VW'(r_cold - SW'(1))};
            S_R7: begin
                awe = 1'b1; awd = q_a;
            end
            S_R9: begin
                nwe = 1'b1; nwd = {r_rslot, q_n[VW-1:0]};
            end
            S_R11: begin
                vwe = 1'b1; vwd = q_v; vwd.slot = r_rslot;
            end
            S_T1: begin
                vwe = 1'b1; vwa = r_i; vwd = q_v;
                vwd.age = age_sum[AGE_BITS] ? '1 : age_sum[AGE_BITS-1:0];
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:  if (r_clr == 11'(fva_pkg::NOTE_MAP_DEPTH - 1)) n_state = S_IDLE;
            S_IDLE: if (in_go) begin
                case (s_axis_tuser)
                    fva_pkg::KIND_NOTE_ON, fva_pkg::KIND_NOTE_OFF: n_state = S_LKP;
                    fva_pkg::KIND_ALL_OFF: if (c_cnt != '0) n_state = S_R0;
                    fva_pkg::KIND_TICK:    n_state = S_T0;
                    default: ;
                endcase
            end
            S_LKP: n_state = S_LKD;
            S_LKD: begin
                if (is_off) n_state = (q_n[NMW-1:VW] == '0) ? S_IDLE : S_R0;
                else        n_state = (q_n[NMW-1:VW] != '0 || perc_bad) ? S_IDLE : S_SA;
            end
            S_SA:  n_state = S_SB;
            S_SB:  n_state = S_SC;
            S_SC:  n_state = (r_i == VW'(VOICES - 1)) ? S_WIN : S_SA;
            S_WIN: n_state = S_WD;
            S_WD:  n_state = q_v.busy ? S_R0 : S_ON;
            S_ON:  if (out_free) n_state = S_IDLE;
            S_R0:  n_state = S_R1;
            S_R1:  n_state = S_R2;
            S_R2:  n_state = S_R3;
            S_R3:  n_state = S_R4;
            S_R4:  n_state = S_R5;
            S_R5:  if (out_free) n_state = (r_rslot == r_cold) ? S_RET : S_R6;
            S_R6:  n_state = S_R7;
            S_R7:  n_state = S_R8;
            S_R8:  n_state = S_R9;
            S_R9:  n_state = S_R10;
            S_R10: n_state = S_R11;
            S_R11: n_state = S_RET;
            S_RET: begin
                case (r_ret)
                    RET_ALL: n_state = (r_rslot == SW'(1)) ? S_IDLE : S_R0;
                    RET_ON:  n_state = S_ON;
                    default: n_state = S_IDLE;
                endcase
            end
            S_T0:  n_state = S_T1;
            S_T1:  n_state = (r_i == VW'(VOICES - 1)) ? S_IDLE : S_T0;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_ovld  <= 1'b0;
            for (int c = 0; c < fva_pkg::CHANNELS; c++) begin
                r_patch[c] <= '0;
                r_count[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) r_clr <= r_clr + 11'd1;
            // drop valid after a transfer unless a new action loads this cycle
            if (m_axis_tready && !(out_free && (r_state == S_ON || r_state == S_R5)))
                r_ovld <= 1'b0;
            case (r_state)
                S_IDLE: if (in_go) begin
                    r_kind <= s_axis_tuser;
                    r_ch   <= in_ch;
                    r_rch  <= in_ch;
                    r_note <= in_note;
                    r_vel  <= in_vel;
                    r_el   <= in_el;
                    r_i    <= '0;
                    r_rslot <= c_cnt;
                    r_ret  <= RET_ALL;
                    if (s_axis_tuser == fva_pkg::KIND_PROGRAM) r_patch[in_ch] <= in_prog;
                end
                S_LKD: begin
                    r_rnote <= r_note;
                    r_rslot <= q_n[NMW-1:VW];
                    r_ret   <= RET_DONE;
                    r_instr <= (r_ch == fva_pkg::PERC_CHANNEL)
                             ? fva_pkg::PERC_BASE + 8'(r_note) - 8'(fva_pkg::PERC_LOW)
                             : {1'b0, r_patch[r_ch]};
                end
                S_SB: begin
                    r_raw  <= RW'({q_v.age, 2'b0}) + RW'(q_v.age) + RW'(bonus);
                    r_perc <= !r_instr[7] && q_v.instr[7];
                end
                S_SC: begin
                    if (r_i == '0 || fin > r_bscore) begin
                        r_bscore <= fin;
                        r_best   <= r_i;
                    end
                    r_i <= r_i + VW'(1);
                end
                S_WD: begin
                    // steal: release the winner's note first
                    r_rch   <= q_v.busy ? q_v.owner : r_ch;
                    r_rslot <= q_v.slot;
                    r_ret   <= RET_ON;
                end
                S_ON: if (out_free) begin
                    r_count[r_rch] <= c_cnt + SW'(1);
                    r_ovld   <= 1'b1;
                    r_oact   <= fva_pkg::ACT_KEY_ON;
                    r_ovoice <= 5'(r_best);
                    r_och    <= r_ch;
                    r_onote  <= r_note;
                    r_oinstr <= r_instr;
                    r_ovel   <= r_vel;
                    r_olast  <= 1'b1;
                end
                S_R1: r_rnote <= q_a;
                S_R3: begin
                    r_v     <= q_n[VW-1:0];
                    r_cold  <= c_cnt;
                    r_count[r_rch] <= c_cnt - SW'(1);
                end
                S_R5: if (out_free) begin
                    r_ovld   <= 1'b1;
                    r_oact   <= fva_pkg::ACT_KEY_OFF;
                    r_ovoice <= 5'(r_v);
                    r_och    <= r_rch;
                    r_onote  <= r_rnote;
                    r_oinstr <= q_v.instr;
                    r_ovel   <= '0;
                    r_olast  <= (r_ret == RET_DONE) ||
                                (r_ret == RET_ALL && r_rslot == SW'(1));
                end
                S_R7: r_rnote <= q_a;
                S_R9: r_v <= q_n[VW-1:0];
                S_RET: begin
                    if (r_ret == RET_ALL) r_rslot <= r_rslot - SW'(1);
                    if (r_ret == RET_ON)  r_rch   <= r_ch;
                end
                S_T1: r_i <= r_i + VW'(1);
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {1'b0, r_ovel, r_oinstr, r_onote, r_och, r_ovoice};
    assign m_axis_tuser  = r_oact;
    assign m_axis_tlast  = r_olast;

endmodule
